### src/assert_macros.svh
// Assertion macros for the tally unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Assert that an antecedent implies a consequent on the same edge.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an expression holds on every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, expr)
`endif
`endif

### src/krt_pkg.sv
package krt_pkg;
  localparam int unsigned MaxSlotsDef = 256;
  localparam int unsigned MaxColumns = 8;
  localparam int unsigned MaxReactions = 8;
  localparam int unsigned ColW = 3;

  localparam logic [1:0] ACT_TALLY = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_NONE = 3'd1;
  localparam logic [2:0] ST_FILTER = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [2:0] REG_GROUP = 3'd0;
  localparam logic [2:0] REG_MODEL = 3'd1;
  localparam logic [2:0] REG_USEMAP = 3'd2;
  localparam logic [2:0] REG_COLCNT = 3'd3;
  localparam logic [2:0] REG_COLMAP = 3'd4;

  // Configuration values seen by the core.
  typedef struct packed {
    logic [31:0] group_bits;
    logic [7:0]  model_id;
    logic        use_column_map;
    logic [3:0]  column_count;
    logic [63:0] column_map;
  } cfg_t;
endpackage

### src/krt_regs.sv
module krt_regs
  import krt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  logic [2:0] idx;
  assign idx = paddr[5:3];
  assign pready = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.group_bits <= 32'd1;
      cfg.model_id <= 8'd0;
      cfg.use_column_map <= 1'b0;
      cfg.column_count <= 4'd8;
      cfg.column_map <= 64'd0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_GROUP: cfg.group_bits <= pwdata[31:0];
        REG_MODEL: cfg.model_id <= pwdata[7:0];
        REG_USEMAP: cfg.use_column_map <= pwdata[0];
        REG_COLCNT: cfg.column_count <= pwdata[3:0];
        REG_COLMAP: cfg.column_map <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_GROUP: prdata = {32'd0, cfg.group_bits};
      REG_MODEL: prdata = {56'd0, cfg.model_id};
      REG_USEMAP: prdata = {63'd0, cfg.use_column_map};
      REG_COLCNT: prdata = {60'd0, cfg.column_count};
      REG_COLMAP: prdata = cfg.column_map;
      default: prdata = '0;
    endcase
  end
endmodule

### src/keyed_reaction_tally_unit.sv
// Channel | Direction | Signals
// in      | to unit   | in_valid, in_ready, action, surf_id, surf_mask, surf_model,
//         |           | reaction, read_slot
// out     | from unit | out_valid, out_ready, status, slot_index, new_entry,
//         |           | entries_in_use, read_surf_id, column_index, count_value, last
// cfg     | to unit   | APB psel/penable/pwrite/paddr/pwdata/prdata/pready
// A tally walks the key memory slot by slot, S_SCAN issuing the address and
// S_SCHK comparing the key; the counter row is then read (S_CRD) and written
// back (S_CWR) one column at a time, over all MaxColumns columns on every
// tally. A read steps through S_RRD, S_RWT and S_RSEND for each column. Clear
// and filtered words go from S_IDLE straight to S_OUT. Synchronous reset
// empties the table at once; no clearing pass. A stalled output holds the unit.
module keyed_reaction_tally_unit
  import krt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MaxSlotsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] surf_id,
  input  logic [31:0] surf_mask,
  input  logic [7:0]  surf_model,
  input  logic [3:0]  reaction,
  input  logic [7:0]  read_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  slot_index,
  output logic        new_entry,
  output logic [8:0]  entries_in_use,
  output logic [31:0] read_surf_id,
  output logic [2:0]  column_index,
  output logic [31:0] count_value,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int unsigned SW = $clog2(MAX_SLOTS);
  localparam int unsigned CW = SW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCHK, S_ALLOC, S_CRD, S_CWR, S_RRD, S_RWT, S_RSEND, S_OUT
  } state_t;

  cfg_t cfg;
  krt_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Memories: keys and counters, registered read.
  logic [31:0] key_mem [MAX_SLOTS];
  logic [31:0] cnt_mem [MAX_SLOTS*MaxColumns];
  logic [31:0] key_q, cnt_q;
  logic [SW-1:0] key_raddr;
  logic [SW+ColW-1:0] cnt_raddr, cnt_waddr;
  logic key_we, cnt_we;
  logic [31:0] cnt_wdata;

  state_t state;
  logic [CW-1:0] used, scan;
  logic [SW-1:0] slot;
  logic [ColW:0] col;
  logic [3:0] ncol;
  logic [7:0] rowbits;
  logic isnew;
  logic [31:0] id_r;
  logic [2:0] rcol;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[slot] <= id_r;
    key_q <= key_mem[key_raddr];
  end
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[cnt_raddr];
  end

  // Effective column count and the reaction's column set.
  logic [3:0] ncol_in;
  logic [2:0] r_in;
  logic [7:0] map_row;
  logic filt;
  always_comb begin
    ncol_in = (cfg.column_count == 4'd0) ? 4'd1 :
              (cfg.column_count > 4'(MaxColumns)) ? 4'(MaxColumns) : cfg.column_count;
    r_in = 3'(reaction - 4'd1);
    map_row = cfg.column_map[{r_in, 3'b000} +: 8];
    filt = ((surf_mask & cfg.group_bits) == 32'd0) || (surf_model != cfg.model_id) ||
           (reaction > 4'(MaxReactions)) ||
           (!cfg.use_column_map && ({1'b0, r_in} >= ncol_in));
  end

  // Only columns in use are bumped.
  logic cur_bit;
  assign cur_bit = rowbits[col[ColW-1:0]] && (col < ncol);
  // Key read address stays on the read slot during a read run.
  assign key_raddr = (state == S_IDLE) ? SW'(read_slot) :
                     (state == S_SCAN) ? scan[SW-1:0] : slot;
  assign cnt_raddr = {slot, col[ColW-1:0]};
  assign cnt_waddr = {slot, col[ColW-1:0]};
  assign in_ready = (state == S_IDLE);

  always_comb begin
    key_we = (state == S_ALLOC);
    cnt_we = 1'b0;
    cnt_wdata = '0;
    if (state == S_ALLOC) begin
      cnt_we = 1'b0;
    end
    if (state == S_CWR) begin
      cnt_we = 1'b1;
      if (isnew) cnt_wdata = cur_bit ? 32'd1 : 32'd0;
      else cnt_wdata = (cur_bit && cnt_q != 32'hFFFF_FFFF) ? cnt_q + 32'd1 : cnt_q;
    end
  end

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          status <= ST_FILTER; slot_index <= '0; new_entry <= 1'b0;
          read_surf_id <= '0; column_index <= '0; count_value <= '0; last <= 1'b1;
          entries_in_use <= 9'(used);
          id_r <= surf_id; ncol <= ncol_in; col <= '0; scan <= '0;
          rowbits <= cfg.use_column_map ? map_row : (8'd1 << r_in);
          priority if (action == ACT_CLEAR) begin
            used <= '0; status <= ST_DONE; entries_in_use <= '0;
            out_valid <= 1'b1; state <= S_OUT;
          end else if (action == ACT_READ) begin
            if ({1'b0, read_slot} < 9'(used) && 32'(read_slot) < MAX_SLOTS) begin
              slot <= SW'(read_slot); state <= S_RRD;
            end else begin
              out_valid <= 1'b1; state <= S_OUT;
            end
          end else if (action != ACT_TALLY) begin
            out_valid <= 1'b1; state <= S_OUT;
          end else if (reaction == 4'd0) begin
            status <= ST_NONE; out_valid <= 1'b1; state <= S_OUT;
          end else if (filt) begin
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Key at scan is requested; compare next cycle.
          if (scan >= used) begin
            if (32'(used) >= MAX_SLOTS) begin
              status <= ST_FULL; out_valid <= 1'b1; state <= S_OUT;
            end else begin
              slot <= used[SW-1:0]; isnew <= 1'b1; state <= S_ALLOC;
            end
          end else state <= S_SCHK;
        end
        S_SCHK: begin
          if (key_q == id_r) begin
            slot <= scan[SW-1:0]; isnew <= 1'b0; state <= S_CRD;
          end else begin
            scan <= scan + 1'b1; state <= S_SCAN;
          end
        end
        S_ALLOC: begin
          used <= used + 1'b1; state <= S_CRD;
        end
        S_CRD: state <= S_CWR;
        S_CWR: begin
          if (col[ColW-1:0] == ColW'(MaxColumns - 1)) begin
            status <= ST_COUNTED; slot_index <= 8'(slot); new_entry <= isnew;
            read_surf_id <= id_r; entries_in_use <= 9'(used);
            out_valid <= 1'b1; state <= S_OUT;
          end else begin
            col <= col + 1'b1; state <= S_CRD;
          end
        end
        S_RRD: state <= S_RWT;
        S_RWT: begin
          status <= ST_DONE; slot_index <= 8'(slot); read_surf_id <= key_q;
          column_index <= col[ColW-1:0]; count_value <= cnt_q;
          last <= ((col + 1'b1) == ncol);
          out_valid <= 1'b1; state <= S_RSEND;
        end
        S_RSEND: if (out_ready) begin
          out_valid <= 1'b0;
          if (last) state <= S_IDLE;
          else begin
            col <= col + 1'b1; state <= S_RRD;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_ALWAYS(a_used_bound, clk, rst, 32'(used) <= MAX_SLOTS)
  `ASSERT_IMPL(a_busy_no_ready, clk, rst, out_valid, !in_ready)
  `ASSERT_IMPL(a_cnt_we_state, clk, rst, cnt_we, state == S_CWR)
endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench
  import krt_pkg::*;
();

  localparam int unsigned SlotCount = 256;
  localparam int unsigned DrainCycles = 320;
  localparam int unsigned WatchdogLimit = 6000;
  localparam int unsigned HoldCycles = 400;

  // One input word and one result word as seen on the ports.
  typedef struct {
    logic [1:0]  action;
    logic [31:0] surf_id;
    logic [31:0] surf_mask;
    logic [7:0]  surf_model;
    logic [3:0]  reaction;
    logic [7:0]  read_slot;
  } tally_in_t;

  typedef struct {
    logic [2:0]  status;
    logic [7:0]  slot_index;
    logic        new_entry;
    logic [8:0]  entries_in_use;
    logic [31:0] read_surf_id;
    logic [2:0]  column_index;
    logic [31:0] count_value;
    logic        last;
  } tally_out_t;

  // A directed row; when pinned is set, the status is typed in by hand.
  typedef struct {
    tally_in_t  word;
    bit         pinned;
    logic [2:0] pin_status;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] surf_id;
  logic [31:0] surf_mask;
  logic [7:0]  surf_model;
  logic [3:0]  reaction;
  logic [7:0]  read_slot;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [7:0]  slot_index;
  logic        new_entry;
  logic [8:0]  entries_in_use;
  logic [31:0] read_surf_id;
  logic [2:0]  column_index;
  logic [31:0] count_value;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  keyed_reaction_tally_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .surf_id(surf_id), .surf_mask(surf_mask),
    .surf_model(surf_model), .reaction(reaction), .read_slot(read_slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_index(slot_index), .new_entry(new_entry),
    .entries_in_use(entries_in_use), .read_surf_id(read_surf_id),
    .column_index(column_index), .count_value(count_value), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow copy of the configuration and of the tally table.
  logic [31:0] sh_group;
  logic [7:0]  sh_model;
  logic        sh_usemap;
  logic [3:0]  sh_colcnt;
  logic [63:0] sh_colmap;
  logic [31:0] sh_key [SlotCount];
  bit          sh_valid [SlotCount];
  logic [31:0] sh_count [SlotCount][MaxColumns];
  int unsigned sh_used;

  tally_out_t  expected_words[$];
  bit          pin_next;
  logic [2:0]  pin_status_next;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cur_phase;
  bit          held;
  int unsigned hold_cnt;
  logic [31:0] id_pool [12];

  function automatic int unsigned live_columns();
    if (sh_colcnt == 4'd0) return 1;
    if (sh_colcnt > MaxColumns) return MaxColumns;
    return sh_colcnt;
  endfunction

  function automatic tally_out_t blank_word(logic [2:0] st);
    tally_out_t w;
    w.status = st;
    w.slot_index = '0;
    w.new_entry = 1'b0;
    w.entries_in_use = sh_used[8:0];
    w.read_surf_id = '0;
    w.column_index = '0;
    w.count_value = '0;
    w.last = 1'b1;
    return w;
  endfunction

  // Update the shadow table for one accepted word and queue its results.
  task automatic predict_tally(tally_in_t it);
    int unsigned ncol;
    int unsigned r;
    int unsigned slot;
    bit found;
    tally_out_t w;
    ncol = live_columns();
    if (it.action == ACT_CLEAR) begin
      foreach (sh_valid[s]) sh_valid[s] = 1'b0;
      sh_used = 0;
      expected_words.push_back(blank_word(ST_DONE));
    end else if (it.action == ACT_READ) begin
      if (it.read_slot >= sh_used || !sh_valid[it.read_slot]) begin
        expected_words.push_back(blank_word(ST_FILTER));
      end else begin
        for (int c = 0; c < ncol; c++) begin
          w = blank_word(ST_DONE);
          w.slot_index = it.read_slot;
          w.read_surf_id = sh_key[it.read_slot];
          w.column_index = c[2:0];
          w.count_value = sh_count[it.read_slot][c];
          w.last = (c + 1 == ncol);
          expected_words.push_back(w);
        end
      end
    end else if (it.action != ACT_TALLY) begin
      expected_words.push_back(blank_word(ST_FILTER));
    end else if (it.reaction == 4'd0) begin
      expected_words.push_back(blank_word(ST_NONE));
    end else begin
      r = it.reaction - 1;
      if ((it.surf_mask & sh_group) == 0 || it.surf_model != sh_model ||
          it.reaction > MaxReactions || (!sh_usemap && r >= ncol)) begin
        expected_words.push_back(blank_word(ST_FILTER));
      end else begin
        found = 1'b0;
        slot = 0;
        for (int s = 0; s < sh_used; s++) begin
          if (!found && sh_valid[s] && sh_key[s] == it.surf_id) begin
            slot = s;
            found = 1'b1;
          end
        end
        if (!found && sh_used >= SlotCount) begin
          expected_words.push_back(blank_word(ST_FULL));
        end else begin
          if (!found) begin
            slot = sh_used;
            sh_key[slot] = it.surf_id;
            sh_valid[slot] = 1'b1;
            for (int c = 0; c < MaxColumns; c++) sh_count[slot][c] = '0;
            sh_used++;
          end
          for (int c = 0; c < MaxColumns; c++) begin
            if ((sh_usemap && c < ncol && sh_colmap[8 * r + c]) || (!sh_usemap && c == r)) begin
              if (sh_count[slot][c] != 32'hFFFF_FFFF) sh_count[slot][c]++;
            end
          end
          w = blank_word(ST_COUNTED);
          w.slot_index = slot[7:0];
          w.new_entry = !found;
          w.read_surf_id = it.surf_id;
          expected_words.push_back(w);
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Scoreboard: results are checked first, then the accepted word is predicted.
  always @(posedge clk) begin
    tally_in_t it;
    tally_out_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual status %0h", $time, status);
        end else begin
          w = expected_words.pop_front();
          check_field("status", w.status, status);
          check_field("slot_index", w.slot_index, slot_index);
          check_field("new_entry", w.new_entry, new_entry);
          check_field("entries_in_use", w.entries_in_use, entries_in_use);
          check_field("read_surf_id", w.read_surf_id, read_surf_id);
          check_field("column_index", w.column_index, column_index);
          check_field("count_value", w.count_value, count_value);
          check_field("last", w.last, last);
        end
      end
      if (in_valid && in_ready) begin
        it.action = action;
        it.surf_id = surf_id;
        it.surf_mask = surf_mask;
        it.surf_model = surf_model;
        it.reaction = reaction;
        it.read_slot = read_slot;
        predict_tally(it);
        // A hand-typed status stands in for the predicted one.
        if (pin_next) expected_words[expected_words.size() - 1].status = pin_status_next;
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off in the last random phase.
  always @(negedge clk) begin
    if (cur_phase == 3 && !held) begin
      held = 1'b1;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One register write; the caller releases the bus after the last one.
  task automatic write_reg(logic [2:0] index, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (index)
      REG_GROUP: sh_group = value[31:0];
      REG_MODEL: sh_model = value[7:0];
      REG_USEMAP: sh_usemap = value[0];
      REG_COLCNT: sh_colcnt = value[3:0];
      REG_COLMAP: sh_colmap = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic setup(logic [31:0] grp, logic [7:0] mdl, logic umap, logic [3:0] cc,
                       logic [63:0] cmap);
    write_reg(REG_GROUP, {32'd0, grp});
    write_reg(REG_MODEL, {56'd0, mdl});
    write_reg(REG_USEMAP, {63'd0, umap});
    write_reg(REG_COLCNT, {60'd0, cc});
    write_reg(REG_COLMAP, cmap);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one word; entered and left at a falling edge.
  task automatic send_word(tally_in_t it, bit pin, logic [2:0] pst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= it.action;
    surf_id <= it.surf_id;
    surf_mask <= it.surf_mask;
    surf_model <= it.surf_model;
    reaction <= it.reaction;
    read_slot <= it.read_slot;
    pin_next <= pin;
    pin_status_next <= pst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic tally_in_t word_of(logic [1:0] act, logic [31:0] id, logic [31:0] mask,
                                        logic [7:0] mdl, logic [3:0] rx, logic [7:0] rs);
    tally_in_t it;
    it.action = act;
    it.surf_id = id;
    it.surf_mask = mask;
    it.surf_model = mdl;
    it.reaction = rx;
    it.read_slot = rs;
    return it;
  endfunction

  // Mostly well-formed tallies on a small set of IDs, with reads and noise.
  function automatic tally_in_t random_word();
    tally_in_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.action = pick < 70 ? ACT_TALLY : pick < 90 ? ACT_READ : pick < 95 ? ACT_CLEAR : 2'd3;
    it.surf_id = ($urandom_range(99) < 80) ? id_pool[$urandom_range(11)] : $urandom;
    it.surf_mask = ($urandom_range(99) < 85) ? ($urandom | sh_group) : $urandom;
    it.surf_model = ($urandom_range(99) < 85) ? sh_model : 8'($urandom);
    pick = $urandom_range(99);
    it.reaction = pick < 80 ? 4'($urandom_range(8, 1)) :
                  pick < 90 ? 4'd0 : 4'($urandom_range(15, 9));
    if (sh_used > 0 && $urandom_range(99) < 85) it.read_slot = 8'($urandom_range(sh_used - 1));
    else it.read_slot = 8'($urandom);
    return it;
  endfunction

  task automatic settle();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  row_t rows[$];

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    action = '0;
    surf_id = '0;
    surf_mask = '0;
    surf_model = '0;
    reaction = '0;
    read_slot = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pin_next = 1'b0;
    pin_status_next = '0;
    errors = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_phase = 0;
    held = 1'b0;
    hold_cnt = 0;
    sh_group = 32'd1;
    sh_model = 8'd0;
    sh_usemap = 1'b0;
    sh_colcnt = 4'd8;
    sh_colmap = '0;
    sh_used = 0;
    foreach (sh_valid[s]) sh_valid[s] = 1'b0;
    foreach (id_pool[k]) id_pool[k] = $urandom;
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part under reset settings: group 1, model 0, direct, 8 columns.
    rows.push_back('{word_of(ACT_TALLY, 32'd7, 32'd1, 8'd0, 4'd0, 8'd0), 1, ST_NONE});
    rows.push_back('{word_of(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 4'hF, 8'hFF),
                     1, ST_FILTER});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd0, 32'd1, 8'd0, 4'd1, 8'd0), 1, ST_COUNTED});
    rows.push_back('{word_of(ACT_TALLY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 4'd8, 8'hFF),
                     1, ST_COUNTED});
    rows.push_back('{word_of(ACT_TALLY, 32'd3, 32'd0, 8'd0, 4'd2, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd3, 32'hFFFF_FFFE, 8'd0, 4'd2, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd3, 32'd1, 8'hFF, 4'd2, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd3, 32'd1, 8'd0, 4'd9, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd3, 32'd1, 8'd0, 4'd15, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd0, 32'd1, 8'd0, 4'd8, 8'd0), 0, ST_COUNTED});
    rows.push_back('{word_of(ACT_TALLY, 32'd0, 32'd1, 8'd0, 4'd8, 8'd0), 0, ST_COUNTED});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 0, ST_DONE});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd1), 0, ST_DONE});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd2), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'hFF), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_CLEAR, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 1, ST_DONE});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 1, ST_FILTER});
    rows.push_back('{word_of(ACT_TALLY, 32'd5, 32'h8000_0001, 8'd0, 4'd3, 8'd0), 0, ST_COUNTED});
    rows.push_back('{word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 0, ST_DONE});
    foreach (rows[k]) send_word(rows[k].word, rows[k].pinned, rows[k].pin_status);
    in_valid <= 1'b0;
    pin_next <= 1'b0;
    settle();

    // Random phases over several settings and idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          setup(32'hFFFF_FFFF, 8'd0, 1'b0, 4'd8, 64'd0);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          setup($urandom, 8'hFF, 1'b1, 4'd15, {$urandom, $urandom});
          send_idle_pct = 88;
          recv_stall_pct = 0;
        end
        2: begin
          setup(32'h0000_FFFF, 8'd42, 1'b0, 4'd0, {$urandom, $urandom});
          send_idle_pct = 0;
          recv_stall_pct = 88;
        end
        default: begin
          setup(32'hFFFF_FFFF, 8'd0, 1'b1, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      cur_phase = ph;
      repeat (25) send_word(random_word(), 1'b0, ST_DONE);
      in_valid <= 1'b0;
      settle();
    end

    // Fill the table to the brim, overflow it, read the top slot, then empty it.
    setup(32'hFFFF_FFFF, 8'd0, 1'b0, 4'd1, 64'd0);
    send_idle_pct = 0;
    recv_stall_pct = 10;
    send_word(word_of(ACT_CLEAR, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 1'b0, ST_DONE);
    for (int k = 0; k < SlotCount + 6; k++) begin
      send_word(word_of(ACT_TALLY, 32'h1000 + k, $urandom | 32'd1, 8'd0, 4'd1, 8'd0),
                1'b0, ST_DONE);
    end
    send_word(word_of(ACT_TALLY, 32'h1000, 32'd1, 8'd0, 4'd1, 8'd0), 1'b0, ST_DONE);
    send_word(word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'hFF), 1'b0, ST_DONE);
    send_word(word_of(ACT_READ, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 1'b0, ST_DONE);
    send_word(word_of(ACT_CLEAR, 32'd0, 32'd0, 8'd0, 4'd0, 8'd0), 1'b0, ST_DONE);
    in_valid <= 1'b0;
    settle();

    // Closing stretch with no idling on either side.
    setup(32'd1, 8'd0, 1'b1, 4'd8, {$urandom, $urandom});
    recv_stall_pct = 0;
    cur_phase = 5;
    repeat (30) send_word(random_word(), 1'b0, ST_DONE);
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
